FILE: rtl/core/mtsl_pkg.sv
// ----------------------------------------------------------------------------
// mtsl_pkg
// Shared types and codes of the two-list sorted merge unit.
// ----------------------------------------------------------------------------
`default_nettype none

package mtsl_pkg;

	// Command codes carried on func.
	localparam logic [1:0] FUNC_APPEND_A = 2'd0;
	localparam logic [1:0] FUNC_APPEND_B = 2'd1;
	localparam logic [1:0] FUNC_MERGE    = 2'd2;

	localparam int FUNC_WIDTH   = 2;
	localparam int ELEM_WIDTH   = 32;
	localparam int RESULT_WIDTH = 32;

	typedef enum logic {
		ST_IDLE,
		ST_MERGE
	} state_t;

	// Control group from the merge sequencer to the top level.
	typedef struct packed {
		logic busy;    // a merge run is in progress
		logic emit;    // one merged element leaves this cycle
		logic take_a;  // the element comes from list A, else from list B
		logic last;    // this element ends the run
	} seq_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/core/mtsl_list_mem.sv
// ----------------------------------------------------------------------------
// mtsl_list_mem
// One list store: single write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module mtsl_list_mem #(
	parameter int DEPTH = 32,
	parameter int WIDTH = 32
) (
	input  logic                                   clk,
	input  logic                                   wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                       wr_data,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                       rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

FILE: rtl/core/mtsl_seq.sv
// ----------------------------------------------------------------------------
// mtsl_seq
// Merge sequencer: walks both lists with one shared signed comparator.
// ----------------------------------------------------------------------------
`default_nettype none

module mtsl_seq #(
	parameter int DEPTH = 32,
	parameter int VW    = 32
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         merge_go,
	input  logic [$clog2(DEPTH+1)-1:0]                   cnt_a,
	input  logic [$clog2(DEPTH+1)-1:0]                   cnt_b,
	input  logic signed [VW-1:0]                         head_a,
	input  logic signed [VW-1:0]                         head_b,
	output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr_a,
	output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr_b,
	output mtsl_pkg::seq_ctl_t                           ctl
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int RW = $clog2(2 * DEPTH + 1);

	mtsl_pkg::state_t state_q, state_nxt;

	logic [CW-1:0] ia_q, ib_q, na_q, nb_q;
	logic [CW-1:0] ia_inc, ib_inc;
	logic [RW-1:0] rem_q, total;
	logic          a_left, b_left, take_a, last;

	assign total  = RW'(cnt_a) + RW'(cnt_b);
	assign a_left = ia_q < na_q;
	assign b_left = ib_q < nb_q;
	// On a tie the head of A goes first.
	assign take_a = !b_left || (a_left && !(head_b < head_a));
	assign ia_inc = ia_q + CW'(1);
	assign ib_inc = ib_q + CW'(1);
	assign last   = rem_q == RW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mtsl_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt  = state_q;
		ctl.busy   = 1'b0;
		ctl.emit   = 1'b0;
		ctl.take_a = take_a;
		ctl.last   = last;
		addr_a     = '0;
		addr_b     = '0;
		case (state_q)
			mtsl_pkg::ST_IDLE: begin
				// The read ports sit on entry 0 so both heads are ready when a run starts.
				if (merge_go && (total != '0)) begin
					state_nxt = mtsl_pkg::ST_MERGE;
				end
			end
			mtsl_pkg::ST_MERGE: begin
				ctl.busy = 1'b1;
				ctl.emit = 1'b1;
				addr_a   = take_a ? ia_inc[AW-1:0] : ia_q[AW-1:0];
				addr_b   = take_a ? ib_q[AW-1:0] : ib_inc[AW-1:0];
				if (last) begin
					state_nxt = mtsl_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = mtsl_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ia_q  <= '0;
			ib_q  <= '0;
			na_q  <= '0;
			nb_q  <= '0;
			rem_q <= '0;
		end else if (merge_go && (state_q == mtsl_pkg::ST_IDLE)) begin
			ia_q  <= '0;
			ib_q  <= '0;
			na_q  <= cnt_a;
			nb_q  <= cnt_b;
			rem_q <= total;
		end else if (ctl.emit) begin
			if (take_a) begin
				ia_q <= ia_inc;
			end else begin
				ib_q <= ib_inc;
			end
			rem_q <= rem_q - RW'(1);
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/merge_two_sorted_lists_unit.sv
// ----------------------------------------------------------------------------
// merge_two_sorted_lists_unit
// Loads two ascending lists and emits their two-way merge as a run of results.
// ----------------------------------------------------------------------------
// Usage: a transaction is taken at a rising edge where start is high and busy
// is low. func selects append to list A, append to list B or merge; element
// carries the value for an append. An append gives no result; the next
// transaction may follow at once. An append to a full list is dropped and
// sets a sticky overflow flag.
// A merge starts its run in the cycle after it is taken, and its first result
// is registered onto the ports from the first step of the run: one result per
// cycle, strobe high for each, last_item on the final one, one comparison of
// the two list heads per cycle through a single shared comparator fed by the
// registered read ports of the two stores. busy is high during the run, and
// the last result is on the ports in the same cycle in which busy is first
// low. Equal heads give the A element first. A merge of two empty lists gives
// one result with empty_merge set, in the cycle after the merge is taken, and
// keeps busy low. overflowed carries the flag as it stood when the merge was
// taken; counts and flag clear then.
// Reset clears the counts, the flag and the sequencer; list contents are not
// cleared and need no clearing. The receiver cannot stall: each result is
// valid for exactly the one cycle in which strobe is high.
// ----------------------------------------------------------------------------
`default_nettype none

module merge_two_sorted_lists_unit #(
	parameter int LIST_DEPTH  = 32,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     start,
	output logic                                     busy,
	input  logic [mtsl_pkg::FUNC_WIDTH-1:0]          func,
	input  logic signed [mtsl_pkg::ELEM_WIDTH-1:0]   element,
	output logic                                     strobe,
	output logic signed [mtsl_pkg::RESULT_WIDTH-1:0] merged_value,
	output logic                                     last_item,
	output logic                                     empty_merge,
	output logic                                     overflowed
);

	localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int CW = $clog2(LIST_DEPTH + 1);

	mtsl_pkg::seq_ctl_t ctl;

	logic                   accept, do_app_a, do_app_b, do_merge, both_empty;
	logic [CW-1:0]          cnt_a_q, cnt_b_q;
	logic                   ovf_q, ovf_run_q;
	logic                   full_a, full_b;
	logic [63:0]            elem_ext, res_ext;
	logic [VALUE_WIDTH-1:0] elem_norm;
	logic signed [VALUE_WIDTH-1:0] head_a, head_b, pick;
	logic [AW-1:0]          addr_a, addr_b;

	logic                                     strobe_q;
	logic signed [mtsl_pkg::RESULT_WIDTH-1:0] value_q;
	logic                                     last_q, empty_q, ovf_out_q;

	assign busy       = ctl.busy;
	assign accept     = start && !busy;
	assign do_app_a   = accept && (func == mtsl_pkg::FUNC_APPEND_A);
	assign do_app_b   = accept && (func == mtsl_pkg::FUNC_APPEND_B);
	assign do_merge   = accept && (func == mtsl_pkg::FUNC_MERGE);
	assign full_a     = cnt_a_q == CW'(LIST_DEPTH);
	assign full_b     = cnt_b_q == CW'(LIST_DEPTH);
	assign both_empty = (cnt_a_q == '0) && (cnt_b_q == '0);

	// Sign-extend the field, then keep the stored width.
	assign elem_ext  = 64'(element);
	assign elem_norm = elem_ext[VALUE_WIDTH-1:0];

	mtsl_list_mem #(
		.DEPTH(LIST_DEPTH),
		.WIDTH(VALUE_WIDTH)
	) u_mem_a (
		.clk     (clk),
		.wr_en   (do_app_a && !full_a),
		.wr_addr (cnt_a_q[AW-1:0]),
		.wr_data (elem_norm),
		.rd_addr (addr_a),
		.rd_data (head_a)
	);

	mtsl_list_mem #(
		.DEPTH(LIST_DEPTH),
		.WIDTH(VALUE_WIDTH)
	) u_mem_b (
		.clk     (clk),
		.wr_en   (do_app_b && !full_b),
		.wr_addr (cnt_b_q[AW-1:0]),
		.wr_data (elem_norm),
		.rd_addr (addr_b),
		.rd_data (head_b)
	);

	mtsl_seq #(
		.DEPTH(LIST_DEPTH),
		.VW   (VALUE_WIDTH)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.merge_go (do_merge),
		.cnt_a    (cnt_a_q),
		.cnt_b    (cnt_b_q),
		.head_a   (head_a),
		.head_b   (head_b),
		.addr_a   (addr_a),
		.addr_b   (addr_b),
		.ctl      (ctl)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_a_q   <= '0;
			cnt_b_q   <= '0;
			ovf_q     <= 1'b0;
			ovf_run_q <= 1'b0;
		end else begin
			if (do_merge) begin
				cnt_a_q   <= '0;
				cnt_b_q   <= '0;
				ovf_q     <= 1'b0;
				ovf_run_q <= ovf_q;
			end
			if (do_app_a) begin
				if (full_a) begin
					ovf_q <= 1'b1;
				end else begin
					cnt_a_q <= cnt_a_q + CW'(1);
				end
			end
			if (do_app_b) begin
				if (full_b) begin
					ovf_q <= 1'b1;
				end else begin
					cnt_b_q <= cnt_b_q + CW'(1);
				end
			end
		end
	end

	assign pick    = ctl.take_a ? head_a : head_b;
	assign res_ext = 64'(pick);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= ctl.emit || (do_merge && both_empty);
		end
	end

	always_ff @(posedge clk) begin
		if (do_merge && both_empty) begin
			value_q   <= '0;
			last_q    <= 1'b1;
			empty_q   <= 1'b1;
			ovf_out_q <= ovf_q;
		end else if (ctl.emit) begin
			value_q   <= res_ext[mtsl_pkg::RESULT_WIDTH-1:0];
			last_q    <= ctl.last;
			empty_q   <= 1'b0;
			ovf_out_q <= ovf_run_q;
		end
	end

	assign strobe       = strobe_q;
	assign merged_value = value_q;
	assign last_item    = last_q;
	assign empty_merge  = empty_q;
	assign overflowed   = ovf_out_q;

	// An empty merge answers with a single result on the next cycle.
	a_empty_merge: assert property (@(posedge clk) disable iff (!arst_n)
		do_merge && both_empty |=> strobe && empty_merge && last_item)
		else $error("empty merge did not give a single marked result");

	// The final element of a run releases the unit.
	a_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.emit && ctl.last |=> !busy && strobe && last_item)
		else $error("run did not end after its last element");

	// A non-empty merge starts a run on the next cycle.
	a_run_start: assert property (@(posedge clk) disable iff (!arst_n)
		do_merge && !both_empty |=> busy && ctl.emit)
		else $error("merge did not start its run");

	// Counts never pass the list depth.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_a_q <= CW'(LIST_DEPTH)) && (cnt_b_q <= CW'(LIST_DEPTH)))
		else $error("list count beyond depth");

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the two-list sorted merge unit. A short table of directed
// commands is followed by random lists, mostly sorted, with appends of A and
// B interleaved. Every accepted command goes through a local copy of the
// list state, which predicts the merge runs. Results are checked field by
// field in order of arrival.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int         LIST_DEPTH   = 32;
	localparam int         RANDOM_ITEMS = 150;
	localparam logic [1:0] FUNC_UNUSED  = 2'd3;

	typedef struct packed {
		logic signed [mtsl_pkg::RESULT_WIDTH-1:0] value;
		logic                                     last;
		logic                                     empty;
		logic                                     ovf;
	} merge_result_t;

	typedef struct packed {
		logic [mtsl_pkg::FUNC_WIDTH-1:0]        f;
		logic signed [mtsl_pkg::ELEM_WIDTH-1:0] e;
		int                                     reps;
		bit                                     typed;
		merge_result_t                          res;
	} stim_row_t;

	localparam merge_result_t EMPTY_CLEAN = '{32'sd0, 1'b1, 1'b1, 1'b0};
	localparam merge_result_t NO_RESULT   = '0;
	localparam int            NUM_ROWS    = 23;

	localparam stim_row_t DIRECTED_ROWS [NUM_ROWS] = '{
		'{mtsl_pkg::FUNC_MERGE,    32'sd0,          1,  1'b1, EMPTY_CLEAN},
		'{FUNC_UNUSED,             32'shFFFF_FFFF,  1,  1'b0, NO_RESULT},
		'{mtsl_pkg::FUNC_MERGE,    32'sd0,          1,  1'b1, EMPTY_CLEAN},
		'{mtsl_pkg::FUNC_APPEND_A, 32'sh8000_0000,  1,  1'b0, NO_RESULT},
		'{mtsl_pkg::FUNC_APPEND_A, 32'sh0000_0000,  1,  1'b0, NO_RESULT},
		'{mtsl_pkg::FUNC_APPEND_A, 32'sh7FFF_FFFF,  1,  1'b0, NO_RESULT},
		'{mtsl_pkg::FUNC_APPEND_B, 32'sh8000_0000,  1,  1'b0, NO_RESULT},
		'{mtsl_pkg::FUNC_APPEND_B, 32'sh0000_0005,  1,  1'b0, NO_RESULT},
		'{mtsl_pkg::FUNC_APPEND_B, 32'sh7FFF_FFFF,  1,  1'b0, NO_RESULT},
		'{mtsl_pkg::FUNC_MERGE,    32'shFFFF_FFFF,  1,  1'b0, NO_RESULT},
		'{mtsl_pkg::FUNC_APPEND_B, 32'sd7,          1,  1'b0, NO_RESULT},
		'{mtsl_pkg::FUNC_APPEND_B, 32'sd9,          1,  1'b0, NO_RESULT},
		'{mtsl_pkg::FUNC_MERGE,    32'sd0,          1,  1'b0, NO_RESULT},
		'{mtsl_pkg::FUNC_APPEND_A, 32'sd1,          1,  1'b0, NO_RESULT},
		'{mtsl_pkg::FUNC_MERGE,    32'sd0,          1,  1'b0, NO_RESULT},
		'{mtsl_pkg::FUNC_APPEND_A, 32'sh0000_0010,  33, 1'b0, NO_RESULT},
		'{mtsl_pkg::FUNC_APPEND_B, 32'shFFFF_FFFF,  1,  1'b0, NO_RESULT},
		'{mtsl_pkg::FUNC_MERGE,    32'sd0,          1,  1'b0, NO_RESULT},
		'{mtsl_pkg::FUNC_MERGE,    32'sd0,          1,  1'b1, EMPTY_CLEAN},
		'{mtsl_pkg::FUNC_APPEND_A, 32'sd5,          1,  1'b0, NO_RESULT},
		'{mtsl_pkg::FUNC_APPEND_A, 32'sd3,          1,  1'b0, NO_RESULT},
		'{mtsl_pkg::FUNC_APPEND_B, 32'sd4,          1,  1'b0, NO_RESULT},
		'{mtsl_pkg::FUNC_MERGE,    32'sd0,          1,  1'b0, NO_RESULT}
	};

	logic                                     clk;
	logic                                     arst_n;
	logic                                     start;
	logic                                     busy;
	logic [mtsl_pkg::FUNC_WIDTH-1:0]          func;
	logic signed [mtsl_pkg::ELEM_WIDTH-1:0]   element;
	logic                                     strobe;
	logic signed [mtsl_pkg::RESULT_WIDTH-1:0] merged_value;
	logic                                     last_item;
	logic                                     empty_merge;
	logic                                     overflowed;

	// Local copy of the list state.
	logic signed [mtsl_pkg::ELEM_WIDTH-1:0] shadow_a [LIST_DEPTH];
	logic signed [mtsl_pkg::ELEM_WIDTH-1:0] shadow_b [LIST_DEPTH];
	int                                     count_a;
	int                                     count_b;
	logic                                   overflow_seen;

	merge_result_t pending_merge_out [$];
	int            failures;
	int            random_items;

	merge_two_sorted_lists_unit #(
		.LIST_DEPTH (LIST_DEPTH),
		.VALUE_WIDTH(32)
	) DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.func        (func),
		.element     (element),
		.strobe      (strobe),
		.merged_value(merged_value),
		.last_item   (last_item),
		.empty_merge (empty_merge),
		.overflowed  (overflowed)
	);

	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Applies one accepted transaction to the local state and queues the
	// merge run that it causes.
	function automatic void apply_list_command(input logic [mtsl_pkg::FUNC_WIDTH-1:0] f,
			input logic signed [mtsl_pkg::ELEM_WIDTH-1:0] e, input bit typed,
			input merge_result_t typed_res);
		int            ia;
		int            ib;
		int            total;
		merge_result_t r;
		ia = 0;
		ib = 0;
		total = count_a + count_b;
		case (f)
			mtsl_pkg::FUNC_APPEND_A: begin
				if (count_a < LIST_DEPTH) begin
					shadow_a[count_a] = e;
					count_a++;
				end else begin
					overflow_seen = 1'b1;
				end
			end
			mtsl_pkg::FUNC_APPEND_B: begin
				if (count_b < LIST_DEPTH) begin
					shadow_b[count_b] = e;
					count_b++;
				end else begin
					overflow_seen = 1'b1;
				end
			end
			mtsl_pkg::FUNC_MERGE: begin
				if (typed) begin
					pending_merge_out.push_back(typed_res);
				end else if (total == 0) begin
					pending_merge_out.push_back('{32'sd0, 1'b1, 1'b1, overflow_seen});
				end else begin
					while (ia < count_a || ib < count_b) begin
						// Equal heads release the A element first.
						if (ib >= count_b || (ia < count_a && !(shadow_b[ib] < shadow_a[ia])))
						begin
							r.value = shadow_a[ia];
							ia++;
						end else begin
							r.value = shadow_b[ib];
							ib++;
						end
						r.last  = (ia + ib == total);
						r.empty = 1'b0;
						r.ovf   = overflow_seen;
						pending_merge_out.push_back(r);
					end
				end
				count_a = 0;
				count_b = 0;
				overflow_seen = 1'b0;
			end
			default: begin
			end
		endcase
	endfunction

	function automatic logic signed [mtsl_pkg::ELEM_WIDTH-1:0] random_value();
		int v;
		case ($urandom_range(0, 3))
			0: begin
				v = $urandom_range(0, 16);
				return v - 8;
			end
			1: return 32'sh8000_0000 + $urandom_range(0, 3);
			2: return 32'sh7FFF_FFFF - $urandom_range(0, 3);
			default: return $urandom;
		endcase
	endfunction

	function automatic int random_length();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return $urandom_range(LIST_DEPTH - 2, LIST_DEPTH + 4);
		if (r == 1)
			return 0;
		return $urandom_range(1, 6);
	endfunction

	// Called right after a rising edge; returns at the edge that takes it.
	task automatic send_command(input logic [mtsl_pkg::FUNC_WIDTH-1:0] f,
			input logic signed [mtsl_pkg::ELEM_WIDTH-1:0] e, input bit typed,
			input merge_result_t typed_res);
		start   <= 1'b1;
		func    <= f;
		element <= e;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		apply_list_command(f, e, typed, typed_res);
	endtask

	task automatic idle_gap(input bit bursting);
		int r;
		int gap;
		r = $urandom_range(0, 9);
		if (bursting || r < 6)
			gap = 0;
		else if (r < 9)
			gap = $urandom_range(1, 3);
		else
			gap = $urandom_range(8, 40);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic run_random_lists();
		int qa [$];
		int qb [$];
		int na;
		int nb;
		bit bursting;
		na = random_length();
		nb = random_length();
		bursting = ($urandom_range(0, 3) == 0);
		repeat (na) qa.push_back(random_value());
		repeat (nb) qb.push_back(random_value());
		if ($urandom_range(0, 9) != 0) begin
			qa.sort();
			qb.sort();
		end
		while (qa.size() + qb.size() > 0) begin
			if (qb.size() == 0 || (qa.size() > 0 && $urandom_range(0, 1) == 1))
				send_command(mtsl_pkg::FUNC_APPEND_A, qa.pop_front(), 1'b0, NO_RESULT);
			else
				send_command(mtsl_pkg::FUNC_APPEND_B, qb.pop_front(), 1'b0, NO_RESULT);
			random_items++;
			idle_gap(bursting);
			if ($urandom_range(0, 15) == 0) begin
				send_command(FUNC_UNUSED, $urandom, 1'b0, NO_RESULT);
				idle_gap(bursting);
			end
		end
		// Now and then the merge is left out, so the next lists pile on top.
		if ($urandom_range(0, 9) != 0) begin
			send_command(mtsl_pkg::FUNC_MERGE, $urandom, 1'b0, NO_RESULT);
			random_items++;
			idle_gap(bursting);
		end
	endtask

	always @(posedge clk) begin
		merge_result_t want;
		if (arst_n && strobe !== 1'b0) begin
			if (pending_merge_out.size() == 0) begin
				$error("unexpected result: merged_value %0d", merged_value);
				failures++;
			end else begin
				want = pending_merge_out.pop_front();
				if (merged_value !== want.value) begin
					$error("merged_value: expected %0d, actual %0d", want.value, merged_value);
					failures++;
				end
				if (last_item !== want.last) begin
					$error("last_item: expected %0b, actual %0b", want.last, last_item);
					failures++;
				end
				if (empty_merge !== want.empty) begin
					$error("empty_merge: expected %0b, actual %0b", want.empty, empty_merge);
					failures++;
				end
				if (overflowed !== want.ovf) begin
					$error("overflowed: expected %0b, actual %0b", want.ovf, overflowed);
					failures++;
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		func = mtsl_pkg::FUNC_APPEND_A;
		element = '0;
		failures = 0;
		random_items = 0;
		count_a = 0;
		count_b = 0;
		overflow_seen = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED_ROWS[i]) begin
			repeat (DIRECTED_ROWS[i].reps) begin
				send_command(DIRECTED_ROWS[i].f, DIRECTED_ROWS[i].e, DIRECTED_ROWS[i].typed,
					DIRECTED_ROWS[i].res);
				idle_gap(1'b0);
			end
		end

		while (random_items < RANDOM_ITEMS)
			run_random_lists();
		send_command(mtsl_pkg::FUNC_MERGE, 32'sd0, 1'b0, NO_RESULT);
		start <= 1'b0;

		while (pending_merge_out.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule

`default_nettype wire
